// ===== rtl/text_and_pixel_framebuffer_writer_assert.svh =====
// Assertion macros used by the framebuffer writer checker
`ifndef TEXT_AND_PIXEL_FRAMEBUFFER_WRITER_ASSERT_SVH
`define TEXT_AND_PIXEL_FRAMEBUFFER_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define FBW_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define FBW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fbw_pkg.sv =====
// Types, command codes and font table for the framebuffer writer
package fbw_pkg;

	localparam int GLYPH_PITCH = 6;
	localparam int GLYPH_COLS  = 5;

	localparam logic [2:0] CMD_CHAR   = 3'd0;
	localparam logic [2:0] CMD_PIXEL  = 3'd1;
	localparam logic [2:0] CMD_CURSOR = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_FIRST   = 8'd32;
	localparam logic [7:0] CHAR_LAST    = 8'd127;

	// 5x8 glyphs from space upward, leftmost column in the top byte, bit 0 at the top
	localparam logic [39:0] FONT_ROM [96] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
	};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic home;
		logic clr_start;
		logic clr_step;
		logic newline_move;
		logic draw_init;
		logic draw_step;
		logic advance;
		logic cursor_set;
		logic pix_read;
		logic pix_write;
		logic byte_read;
		logic res_set;
		logic res_status;
		logic res_from_mem;
		logic out_load;
	} fbw_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [2:0] command;
		logic       row_past_end;
		logic       newline;
		logic       code_bad;
		logic       wrap;
		logic       wrap_clear;
		logic       pix_bad;
		logic       cur_bad;
		logic       rd_bad;
		logic       clr_last;
		logic       draw_last;
	} fbw_stat_t;

endpackage

// ===== rtl/fbw_cmd_if.sv =====
// Command channel: one drawing or read command per word
interface fbw_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] char_code;
	logic [7:0] pixel_x;
	logic [6:0] pixel_y;
	logic [4:0] cursor_col;
	logic [3:0] cursor_line;
	logic [9:0] read_address;

	modport source (
		output valid, command, char_code, pixel_x, pixel_y, cursor_col, cursor_line,
			read_address,
		input  ready
	);
	modport sink (
		input  valid, command, char_code, pixel_x, pixel_y, cursor_col, cursor_line,
			read_address,
		output ready
	);
endinterface

// ===== rtl/fbw_res_if.sv =====
// Result channel: status and read byte, one word per command
interface fbw_res_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] read_data;

	modport source (
		output valid, status, read_data,
		input  ready
	);
	modport sink (
		input  valid, status, read_data,
		output ready
	);
endinterface

// ===== rtl/text_and_pixel_framebuffer_writer.sv =====
// Top level of the page-mode framebuffer writer with 5x8 text
//
// req carries one command word: write character, set pixel, set text
// cursor, clear store, or read one byte. rsp returns exactly one word per
// command: status (1 = rejected) and read_data (the byte for a read, else 0).
// Both channels move a word when valid and ready are high at a clock edge.
// Commands are handled one at a time; req.ready is high only when idle.
// Set pixel is a read-modify-write on the single store port, a drawn
// character makes six store writes, and the whole store is cleared on a
// clear command, a character on a row past the last page, or a wrap off
// the last page. The store port moves at most one byte a cycle.
// After arst_n is released the block clears all DISPLAY_COLUMNS*PAGE_COUNT
// store bytes (1024 by default) with req.ready low.
// A finished result waits in the output register; the next command is
// accepted meanwhile, and its result is held until rsp.ready takes the first.
module text_and_pixel_framebuffer_writer
	import fbw_pkg::*;
#(
	parameter int DISPLAY_COLUMNS = 128,
	parameter int PAGE_COUNT      = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	fbw_cmd_if.sink     req,
	fbw_res_if.source   rsp
);

	fbw_cmd_t  cmd;
	fbw_stat_t stat;

	fbw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbw_dp #(
		.DISPLAY_COLUMNS (DISPLAY_COLUMNS),
		.PAGE_COUNT      (PAGE_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (req.command),
		.char_code    (req.char_code),
		.pixel_x      (req.pixel_x),
		.pixel_y      (req.pixel_y),
		.cursor_col   (req.cursor_col),
		.cursor_line  (req.cursor_line),
		.read_address (req.read_address),
		.status       (rsp.status),
		.read_data    (rsp.read_data)
	);

endmodule

// ===== rtl/fbw_dp.sv =====
// Datapath: command fields, text cursor, frame store and result registers
module fbw_dp
	import fbw_pkg::*;
#(
	parameter int DISPLAY_COLUMNS = 128,
	parameter int PAGE_COUNT      = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fbw_cmd_t   cmd,
	output fbw_stat_t  stat,
	input  logic [2:0] command,
	input  logic [7:0] char_code,
	input  logic [7:0] pixel_x,
	input  logic [6:0] pixel_y,
	input  logic [4:0] cursor_col,
	input  logic [3:0] cursor_line,
	input  logic [9:0] read_address,
	output logic       status,
	output logic [7:0] read_data
);

	localparam int STORE_BYTES = DISPLAY_COLUMNS * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int XW          = $clog2(DISPLAY_COLUMNS + 1);
	localparam int RW          = $clog2(PAGE_COUNT + 1);
	localparam int CELLS       = DISPLAY_COLUMNS / GLYPH_PITCH;

	logic [2:0]    cmd_q;
	logic [7:0]    code_q;
	logic [7:0]    px_q;
	logic [6:0]    py_q;
	logic [4:0]    ccol_q;
	logic [3:0]    cline_q;
	logic [9:0]    raddr_q;

	logic [XW-1:0] text_x_q;
	logic [RW-1:0] text_row_q;
	logic [AW-1:0] addr_q;
	logic [2:0]    col_q;

	logic          pend_status_q;
	logic [7:0]    pend_data_q;
	logic          out_status_q;
	logic [7:0]    out_data_q;

	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    rd_q;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	logic [AW-1:0] draw_base;
	logic [AW-1:0] pix_addr;
	logic [6:0]    glyph_idx;
	logic [39:0]   glyph_bits;
	logic [7:0]    glyph_byte;

	// Hold the command word while it is worked on
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= command;
			code_q  <= char_code;
			px_q    <= pixel_x;
			py_q    <= pixel_y;
			ccol_q  <= cursor_col;
			cline_q <= cursor_line;
			raddr_q <= read_address;
		end
	end

	// Decode flags for the controller
	always_comb begin
		stat.command      = cmd_q;
		stat.row_past_end = int'(text_row_q) >= PAGE_COUNT;
		stat.newline      = code_q == CHAR_NEWLINE;
		stat.code_bad     = (code_q < CHAR_FIRST) || (code_q > CHAR_LAST);
		stat.wrap         = int'(text_x_q) + GLYPH_PITCH > DISPLAY_COLUMNS;
		stat.wrap_clear   = int'(text_row_q) + 1 >= PAGE_COUNT;
		stat.pix_bad      = (int'(px_q) >= DISPLAY_COLUMNS) || (int'(py_q) >= 8 * PAGE_COUNT);
		stat.cur_bad      = (int'(ccol_q) >= CELLS) || (int'(cline_q) >= PAGE_COUNT);
		stat.rd_bad       = int'(raddr_q) >= STORE_BYTES;
		stat.clr_last     = addr_q == AW'(STORE_BYTES - 1);
		stat.draw_last    = col_q == 3'(GLYPH_PITCH - 1);
	end

	// Byte addresses and the glyph column being drawn
	always_comb begin
		draw_base  = AW'(int'(text_row_q) * DISPLAY_COLUMNS + int'(text_x_q));
		pix_addr   = AW'(int'(px_q) + int'(py_q[6:3]) * DISPLAY_COLUMNS);
		glyph_idx  = 7'(code_q - CHAR_FIRST);
		glyph_bits = FONT_ROM[glyph_idx];
		if (int'(col_q) < GLYPH_COLS) begin
			glyph_byte = glyph_bits[8 * (GLYPH_COLS - 1 - int'(col_q)) +: 8];
		end else begin
			glyph_byte = 8'h00;
		end
	end

	// Text cursor: homing wins over any other move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_x_q   <= '0;
			text_row_q <= '0;
		end else if (cmd.home) begin
			text_x_q   <= '0;
			text_row_q <= '0;
		end else if (cmd.newline_move) begin
			text_x_q   <= '0;
			text_row_q <= text_row_q + RW'(1);
		end else if (cmd.advance) begin
			text_x_q   <= text_x_q + XW'(GLYPH_PITCH);
		end else if (cmd.cursor_set) begin
			text_x_q   <= XW'(int'(ccol_q) * GLYPH_PITCH);
			text_row_q <= RW'(cline_q);
		end
	end

	// Walk address for the clearing pass and glyph drawing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			col_q  <= '0;
		end else begin
			if (cmd.clr_start) begin
				addr_q <= '0;
			end else if (cmd.draw_init) begin
				addr_q <= draw_base;
				col_q  <= '0;
			end else if (cmd.clr_step || cmd.draw_step) begin
				addr_q <= addr_q + AW'(1);
			end
			if (cmd.draw_step) begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	// Select the single store port
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = 8'h00;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
		end else if (cmd.draw_step) begin
			mem_we    = 1'b1;
			mem_wdata = glyph_byte;
		end else if (cmd.pix_read) begin
			mem_re   = 1'b1;
			mem_addr = pix_addr;
		end else if (cmd.pix_write) begin
			mem_we    = 1'b1;
			mem_addr  = pix_addr;
			mem_wdata = rd_q | (8'd1 << py_q[2:0]);
		end else if (cmd.byte_read) begin
			mem_re   = 1'b1;
			mem_addr = AW'(raddr_q);
		end
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Pending result, then the output word
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			pend_status_q <= cmd.res_status;
			pend_data_q   <= 8'h00;
		end else if (cmd.res_from_mem) begin
			pend_status_q <= 1'b0;
			pend_data_q   <= rd_q;
		end
		if (cmd.out_load) begin
			out_status_q <= pend_status_q;
			out_data_q   <= pend_data_q;
		end
	end

	assign status    = out_status_q;
	assign read_data = out_data_q;

endmodule

// ===== rtl/fbw_ctrl.sv =====
// Controller: sequences each command over the datapath
module fbw_ctrl
	import fbw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fbw_stat_t stat,
	output fbw_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_CLEAR     = 4'd2;
	localparam logic [3:0] S_CHAR      = 4'd3;
	localparam logic [3:0] S_DRAW_INIT = 4'd4;
	localparam logic [3:0] S_DRAW      = 4'd5;
	localparam logic [3:0] S_PIX_WAIT  = 4'd6;
	localparam logic [3:0] S_RD_WAIT   = 4'd7;
	localparam logic [3:0] S_FINISH    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] ret_q;
	logic [3:0] ret_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.command)
					CMD_CHAR: begin
						if (stat.row_past_end) begin
							cmd.home      = 1'b1;
							cmd.clr_start = 1'b1;
							ret_d         = S_CHAR;
							state_d       = S_CLEAR;
						end else begin
							state_d = S_CHAR;
						end
					end
					CMD_PIXEL: begin
						if (stat.pix_bad) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = 1'b1;
							state_d        = S_FINISH;
						end else begin
							cmd.pix_read = 1'b1;
							state_d      = S_PIX_WAIT;
						end
					end
					CMD_CURSOR: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = stat.cur_bad;
						cmd.cursor_set = !stat.cur_bad;
						state_d        = S_FINISH;
					end
					CMD_CLEAR: begin
						cmd.res_set   = 1'b1;
						cmd.clr_start = 1'b1;
						ret_d         = S_FINISH;
						state_d       = S_CLEAR;
					end
					CMD_READ: begin
						if (stat.rd_bad) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = 1'b1;
							state_d        = S_FINISH;
						end else begin
							cmd.byte_read = 1'b1;
							state_d       = S_RD_WAIT;
						end
					end
					default: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = 1'b1;
						state_d        = S_FINISH;
					end
				endcase
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ret_q;
				end
			end
			S_CHAR: begin
				if (stat.newline) begin
					cmd.newline_move = 1'b1;
					cmd.res_set      = 1'b1;
					state_d          = S_FINISH;
				end else if (stat.code_bad) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = 1'b1;
					state_d        = S_FINISH;
				end else if (stat.wrap) begin
					cmd.newline_move = 1'b1;
					if (stat.wrap_clear) begin
						cmd.home      = 1'b1;
						cmd.clr_start = 1'b1;
						ret_d         = S_DRAW_INIT;
						state_d       = S_CLEAR;
					end else begin
						state_d = S_DRAW_INIT;
					end
				end else begin
					state_d = S_DRAW_INIT;
				end
			end
			S_DRAW_INIT: begin
				cmd.draw_init = 1'b1;
				state_d       = S_DRAW;
			end
			S_DRAW: begin
				cmd.draw_step = 1'b1;
				if (stat.draw_last) begin
					cmd.advance = 1'b1;
					cmd.res_set = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_PIX_WAIT: begin
				cmd.pix_write = 1'b1;
				cmd.res_set   = 1'b1;
				state_d       = S_FINISH;
			end
			S_RD_WAIT: begin
				cmd.res_from_mem = 1'b1;
				state_d          = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, return point and output valid; reset starts with a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fbw_checker.sv =====
// Port-level checks on the framebuffer writer, bound to the top level
`include "text_and_pixel_framebuffer_writer_assert.svh"

module fbw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_status,
	input logic [7:0] rsp_read_data
);

	logic [1:0] open_q;
	logic       req_take;
	logic       rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// Count commands whose result word has not yet been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
		end else if (req_take && !rsp_take) begin
			open_q <= open_q + 2'd1;
		end else if (rsp_take && !req_take) begin
			open_q <= open_q - 2'd1;
		end
	end

	`FBW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_read_data), "stalled result word changed")
	`FBW_ASSERT_IMPL(a_data_ok, rsp_valid && (rsp_read_data != 8'h00), !rsp_status, "read data on a rejected command")
	`FBW_ASSERT_IMPL(a_no_orphan, rsp_valid, open_q != 2'd0, "result word without a command")
	`FBW_ASSERT_NEXT(a_one_at_a_time, req_take, !req_ready && (open_q != 2'd3), "second command taken while busy")

endmodule

bind text_and_pixel_framebuffer_writer fbw_checker u_fbw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_read_data (rsp.read_data)
);

// ===== tb/sv/fbw_tb_pkg.sv =====
// Command word types and the scoreboard with its mirror of the framebuffer
package fbw_tb_pkg;
	import fbw_pkg::*;

	localparam int FB_COLUMNS  = 128;
	localparam int FB_PAGES    = 8;
	localparam int PAGE_ROWS   = 8;
	localparam int STORE_BYTES = FB_COLUMNS * FB_PAGES;
	localparam int TEXT_CELLS  = FB_COLUMNS / GLYPH_PITCH;

	localparam logic       STATUS_OK    = 1'b0;
	localparam logic       STATUS_BAD   = 1'b1;
	localparam logic [7:0] BLANK_COLUMN = 8'h00;

	// Command codes the block does not know
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int MISMATCH_REPORTS = 10;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] char_code;
		logic [7:0] pixel_x;
		logic [6:0] pixel_y;
		logic [4:0] cursor_col;
		logic [3:0] cursor_line;
		logic [9:0] read_address;
	} fbw_word_t;

	typedef struct {
		bit       status;
		bit [7:0] read_data;
	} fbw_result_t;

	class framebuffer_scoreboard;
		bit [7:0]    frame_bytes [STORE_BYTES];
		int unsigned text_x;
		int unsigned text_row;
		fbw_result_t awaited_results [$];
		int unsigned cmd_count [8];
		int unsigned results_checked;
		int unsigned rejected;
		int unsigned text_wipes;
		int unsigned mismatches;

		function new();
			wipe_store();
			text_x = 0;
			text_row = 0;
		endfunction

		function void wipe_store();
			foreach (frame_bytes[i])
				frame_bytes[i] = 8'h00;
		endfunction

		function void home_and_wipe();
			wipe_store();
			text_x = 0;
			text_row = 0;
			text_wipes++;
		endfunction

		// Draw one character at the cursor; returns the status
		function bit put_char(logic [7:0] code);
			int unsigned base;
			logic [39:0] glyph;
			int          i;
			if (text_row >= FB_PAGES)
				home_and_wipe();
			if (code == CHAR_NEWLINE) begin
				text_x = 0;
				text_row++;
				return STATUS_OK;
			end
			if (code < CHAR_FIRST || code > CHAR_LAST)
				return STATUS_BAD;
			// wrap before the cell would run off the right edge
			if (text_x + GLYPH_PITCH > FB_COLUMNS) begin
				text_x = 0;
				text_row++;
				if (text_row >= FB_PAGES)
					home_and_wipe();
			end
			base = text_row * FB_COLUMNS + text_x;
			glyph = FONT_ROM[code - CHAR_FIRST];
			for (i = 0; i < GLYPH_COLS; i++)
				frame_bytes[base + i] = glyph[39 - 8 * i -: 8];
			frame_bytes[base + GLYPH_COLS] = BLANK_COLUMN;
			text_x += GLYPH_PITCH;
			return STATUS_OK;
		endfunction

		// Apply an accepted command word and queue the result it owes
		function void note_command(fbw_word_t w);
			fbw_result_t r;
			int unsigned idx;
			r.status = STATUS_OK;
			r.read_data = 8'h00;
			cmd_count[w.command]++;
			case (w.command)
				CMD_CHAR: r.status = put_char(w.char_code);
				CMD_PIXEL: begin
					if (w.pixel_x >= FB_COLUMNS || w.pixel_y >= PAGE_ROWS * FB_PAGES) begin
						r.status = STATUS_BAD;
					end else begin
						idx = w.pixel_x + (w.pixel_y / PAGE_ROWS) * FB_COLUMNS;
						frame_bytes[idx] = frame_bytes[idx] | (8'h01 << (w.pixel_y % PAGE_ROWS));
					end
				end
				CMD_CURSOR: begin
					if (w.cursor_col >= TEXT_CELLS || w.cursor_line >= FB_PAGES) begin
						r.status = STATUS_BAD;
					end else begin
						text_x = w.cursor_col * GLYPH_PITCH;
						text_row = w.cursor_line;
					end
				end
				CMD_CLEAR: wipe_store();
				CMD_READ: begin
					if (w.read_address >= STORE_BYTES)
						r.status = STATUS_BAD;
					else
						r.read_data = frame_bytes[w.read_address];
				end
				default: r.status = STATUS_BAD;
			endcase
			if (r.status == STATUS_BAD)
				rejected++;
			awaited_results.push_back(r);
		endfunction

		// Compare an accepted result word with the oldest one owed
		function void check_result(logic status, logic [7:0] read_data);
			fbw_result_t want;
			results_checked++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_REPORTS)
					$display("[%0t] result with no command outstanding: status %0d read_data 0x%02h",
						$realtime, status, read_data);
				return;
			end
			want = awaited_results.pop_front();
			if (status !== want.status || read_data !== want.read_data) begin
				mismatches++;
				if (mismatches <= MISMATCH_REPORTS)
					$display("[%0t] result %0d: expected status %0d read_data 0x%02h, got status %0d read_data 0x%02h",
						$realtime, results_checked, want.status, want.read_data, status, read_data);
			end
		endfunction
	endclass
endpackage

// ===== tb/sv/tb_text_and_pixel_framebuffer_writer.sv =====
// Top of the framebuffer writer testbench: clock, reset, command driver, result sink, watchdog
module tb_text_and_pixel_framebuffer_writer;
	timeunit 1ns;
	timeprecision 1ps;
	import fbw_pkg::*;
	import fbw_tb_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 10;
	localparam int TOTAL_WORDS  = 1350;
	localparam int QUIET_LIMIT  = 6000;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_WAIT     = 4;
	localparam int NEAR_SPAN    = 12;

	logic clk = 1'b0;
	logic arst_n;

	fbw_cmd_if req_ch ();
	fbw_res_if rsp_ch ();

	framebuffer_scoreboard sb;
	fbw_word_t             directed_q [$];
	int                    req_spell = 0;
	bit                    req_calm = 1'b0;
	int                    rsp_spell = 0;
	bit                    rsp_calm = 1'b0;
	int                    quiet_cycles = 0;

	text_and_pixel_framebuffer_writer #(
		.DISPLAY_COLUMNS(FB_COLUMNS),
		.PAGE_COUNT     (FB_PAGES)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Draw a wait length; spells of calm with no idling come and go
	function automatic int draw_wait(ref int spell, ref bit calm);
		if (spell == 0) begin
			spell = $urandom_range(10, 60);
			calm = ($urandom_range(0, 3) == 0);
		end
		spell--;
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic fbw_word_t compose_word(logic [2:0] command, logic [7:0] code,
			logic [7:0] px, logic [6:0] py, logic [4:0] col, logic [3:0] line,
			logic [9:0] addr);
		fbw_word_t w;
		w.command = command;
		w.char_code = code;
		w.pixel_x = px;
		w.pixel_y = py;
		w.cursor_col = col;
		w.cursor_line = line;
		w.read_address = addr;
		return w;
	endfunction

	// Mostly running text with reads near the cursor, salted with bad words
	function automatic fbw_word_t random_word();
		fbw_word_t   w;
		int unsigned pick;
		int unsigned sub;
		int unsigned row;
		int unsigned col;
		w.command = 3'($urandom);
		w.char_code = 8'($urandom);
		w.pixel_x = 8'($urandom);
		w.pixel_y = 7'($urandom);
		w.cursor_col = 5'($urandom);
		w.cursor_line = 4'($urandom);
		w.read_address = 10'($urandom);
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		if (pick < 45) begin
			w.command = CMD_CHAR;
			if (sub < 8)
				w.char_code = CHAR_NEWLINE;
			else if (sub < 11)
				w.char_code = 8'($urandom_range(0, CHAR_FIRST - 1));
			else if (sub < 14)
				w.char_code = 8'($urandom_range(CHAR_LAST + 1, 255));
			else
				w.char_code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
		end else if (pick < 60) begin
			w.command = CMD_PIXEL;
			if (sub < 85) begin
				w.pixel_x = 8'($urandom_range(0, FB_COLUMNS - 1));
				w.pixel_y = 7'($urandom_range(0, PAGE_ROWS * FB_PAGES - 1));
			end
		end else if (pick < 68) begin
			w.command = CMD_CURSOR;
			if (sub < 80) begin
				w.cursor_col = 5'($urandom_range(0, TEXT_CELLS - 1));
				w.cursor_line = 4'($urandom_range(0, FB_PAGES - 1));
			end
		end else if (pick < 95) begin
			w.command = CMD_READ;
			if (sub < 50) begin
				row = (sb.text_row >= FB_PAGES) ? FB_PAGES - 1 : sb.text_row;
				col = (sb.text_x > NEAR_SPAN) ? sb.text_x - $urandom_range(1, NEAR_SPAN)
					: $urandom_range(0, NEAR_SPAN);
				w.read_address = 10'(row * FB_COLUMNS + col);
			end
		end else if (pick < 97) begin
			w.command = CMD_CLEAR;
		end else begin
			w.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return w;
	endfunction

	// Offer one command word and hold it until the block takes it
	task automatic send_word(input fbw_word_t w);
		int gap;
		gap = draw_wait(req_spell, req_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= w.command;
		req_ch.char_code <= w.char_code;
		req_ch.pixel_x <= w.pixel_x;
		req_ch.pixel_y <= w.pixel_y;
		req_ch.cursor_col <= w.cursor_col;
		req_ch.cursor_line <= w.cursor_line;
		req_ch.read_address <= w.read_address;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_command(w);
	endtask

	// Stimulus and end of run
	initial begin
		int spare;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CHAR;
		req_ch.char_code = 8'h00;
		req_ch.pixel_x = 8'h00;
		req_ch.pixel_y = 7'h00;
		req_ch.cursor_col = 5'h00;
		req_ch.cursor_line = 4'h0;
		req_ch.read_address = 10'h000;
		sb = new();

		// store corners after reset, then glyph contents
		directed_q.push_back(compose_word(CMD_READ, 0, 0, 0, 0, 0, 10'd0));
		directed_q.push_back(compose_word(CMD_READ, 0, 0, 0, 0, 0, 10'd1023));
		directed_q.push_back(compose_word(CMD_CHAR, "A", 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_READ, 0, 0, 0, 0, 0, 10'd0));
		directed_q.push_back(compose_word(CMD_CHAR, "0", 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, " ", 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, CHAR_LAST, 0, 0, 0, 0, 0));
		// codes outside the font, then a line break
		directed_q.push_back(compose_word(CMD_CHAR, 8'h00, 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, 8'd128, 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, 8'hff, 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, CHAR_NEWLINE, 0, 0, 0, 0, 0));
		// pixel at the far corner and pixels off the panel
		directed_q.push_back(compose_word(CMD_PIXEL, 0, 8'd127, 7'd63, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_PIXEL, 0, 8'd128, 7'd0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_PIXEL, 0, 8'd0, 7'd64, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_PIXEL, 0, 8'hff, 7'h7f, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_READ, 0, 0, 0, 0, 0, 10'd1023));
		// last cell of the last line, then a wrap off the bottom
		directed_q.push_back(compose_word(CMD_CURSOR, 0, 0, 0, 5'd20, 4'd7, 0));
		directed_q.push_back(compose_word(CMD_CHAR, "W", 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, "X", 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CURSOR, 0, 0, 0, 5'h1f, 4'hf, 0));
		// newline past the last page, then a character on the missing row
		directed_q.push_back(compose_word(CMD_CURSOR, 0, 0, 0, 5'd0, 4'd7, 0));
		directed_q.push_back(compose_word(CMD_CHAR, CHAR_NEWLINE, 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CHAR, "B", 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(compose_word(CMD_SPARE_HI, 0, 0, 0, 0, 0, 0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_q[i])
			send_word(directed_q[i]);
		repeat (TOTAL_WORDS - directed_q.size())
			send_word(random_word());
		req_ch.valid <= 1'b0;

		// drain, then leave room for any stray word
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.awaited_results.size() != 0) begin
			sb.mismatches += sb.awaited_results.size();
			$display("%0d results never arrived", sb.awaited_results.size());
		end
		spare = 0;
		for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
			spare += sb.cmd_count[c];
		$display("Sent %0d words: %0d char, %0d pixel, %0d cursor, %0d clear, %0d read, %0d unknown.",
			TOTAL_WORDS, sb.cmd_count[CMD_CHAR], sb.cmd_count[CMD_PIXEL],
			sb.cmd_count[CMD_CURSOR], sb.cmd_count[CMD_CLEAR], sb.cmd_count[CMD_READ], spare);
		$display("Checked %0d results, %0d rejected; text wrapped or ran off the panel %0d times.",
			sb.results_checked, sb.rejected, sb.text_wipes);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Take result words with random stalls and check each against the mirror
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(rsp_spell, rsp_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			sb.check_result(rsp_ch.status, rsp_ch.read_data);
		end
	end

	// Abort when neither channel moves a word for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no word moved for %0d cycles", QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// ===== text_and_pixel_framebuffer_writer.f =====
+incdir+rtl
rtl/fbw_pkg.sv
rtl/fbw_cmd_if.sv
rtl/fbw_res_if.sv
rtl/fbw_dp.sv
rtl/fbw_ctrl.sv
rtl/text_and_pixel_framebuffer_writer.sv
rtl/fbw_checker.sv
tb/sv/fbw_tb_pkg.sv
tb/sv/tb_text_and_pixel_framebuffer_writer.sv
